FILE: rtl/jet_pkg.sv
`default_nettype none

package jet_pkg;

  // Number format of all internal values: signed Q4.FRAC_BITS.
  localparam int FRAC_BITS    = 28;
  localparam int REG_FRAC     = 28;
  localparam int TEXTURE_SIZE = 512;

  localparam int VAL_W    = FRAC_BITS + 4;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int REG_W    = 32;
  localparam int ZOOM_W   = 31;
  localparam int ITER_W   = 10;
  localparam int COORD_W  = 9;
  localparam int TEX_LOG2 = $clog2(TEXTURE_SIZE);
  localparam int HALF     = TEXTURE_SIZE / 2;
  localparam int STEP_W   = VAL_W - 1 - TEX_LOG2;
  localparam int DIFF_W   = ((COORD_W > TEX_LOG2) ? COORD_W : TEX_LOG2) + 1;
  localparam int START_W  = DIFF_W + STEP_W + 1;
  localparam int TRUNC_W  = PROD_W - FRAC_BITS;
  localparam int SAT_W    = (TRUNC_W > START_W) ? TRUNC_W : START_W;

  // Iteration loop depth; sequence tags must tell apart every pixel in the loop.
  localparam int RING_STAGES = 3;
  localparam int SEQ_W       = $clog2(RING_STAGES + 1);

  // Stream and register port widths.
  localparam int IN_BITS     = 2 * COORD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = ITER_W + 2 * COORD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int ADDR_W      = 4;
  localparam int REG_IDX_W   = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CONST_RE   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CONST_IM   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ZOOM       = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = REG_IDX_W'(3);

  localparam logic [REG_W-1:0]  RST_CONST_RE   = REG_W'(402653184);
  localparam logic [REG_W-1:0]  RST_CONST_IM   = REG_W'(268435456);
  localparam logic [ZOOM_W-1:0] RST_ZOOM       = ZOOM_W'(1073741824);
  localparam logic [ITER_W-1:0] RST_ITER_LIMIT = ITER_W'(64);

  localparam logic signed [VAL_W-1:0] VAL_MAX = $signed({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic signed [VAL_W-1:0] VAL_MIN = $signed({1'b1, {(VAL_W-1){1'b0}}});
  localparam logic signed [SAT_W-1:0] SAT_MAX =
    $signed({{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
  localparam logic signed [SAT_W-1:0] SAT_MIN =
    $signed({{(SAT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});
  localparam logic [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
  localparam logic [VAL_W:0]    FOUR       = (VAL_W+1)'(4) << FRAC_BITS;

  typedef struct packed {
    logic signed [REG_W-1:0] const_re;
    logic signed [REG_W-1:0] const_im;
    logic [ZOOM_W-1:0]       zoom;
    logic [ITER_W-1:0]       iter_limit;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [VAL_W-1:0] zr;
    logic signed [VAL_W-1:0] zi;
  } map_item_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iter_count;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } res_item_t;

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [SAT_W-1:0] v);
    if (v > SAT_MAX) begin
      return VAL_MAX;
    end else if (v < SAT_MIN) begin
      return VAL_MIN;
    end
    return VAL_W'(v);
  endfunction

  // Register value in Q4.REG_FRAC to the internal format; right shifts floor.
  function automatic logic signed [VAL_W-1:0] conv_reg(input logic signed [REG_W-1:0] v);
    logic signed [VAL_W+REG_W-1:0] w;
    w = (VAL_W+REG_W)'(v);
    if (FRAC_BITS >= REG_FRAC) begin
      w = w <<< (FRAC_BITS - REG_FRAC);
    end else begin
      w = w >>> (REG_FRAC - FRAC_BITS);
    end
    return VAL_W'(w);
  endfunction

  // Full product to the internal format: truncate toward zero, then saturate.
  function automatic logic signed [VAL_W-1:0] fmul_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p[PROD_W-1] ? p + $signed(TRUNC_BIAS) : p;
    return sat(SAT_W'(adj >>> FRAC_BITS));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jet_cfg.sv
`default_nettype none

module jet_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [jet_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output jet_pkg::cfg_t                   cfg
);
  import jet_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.const_re   <= RST_CONST_RE;
      cfg.const_im   <= RST_CONST_IM;
      cfg.zoom       <= RST_ZOOM;
      cfg.iter_limit <= RST_ITER_LIMIT;
    end else if (wr) begin
      case (idx)
        REG_CONST_RE:   cfg.const_re   <= pwdata[REG_W-1:0];
        REG_CONST_IM:   cfg.const_im   <= pwdata[REG_W-1:0];
        REG_ZOOM:       cfg.zoom       <= pwdata[ZOOM_W-1:0];
        REG_ITER_LIMIT: cfg.iter_limit <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CONST_RE:   prdata = cfg.const_re;
      REG_CONST_IM:   prdata = cfg.const_im;
      REG_ZOOM:       prdata = 32'(cfg.zoom);
      REG_ITER_LIMIT: prdata = 32'(cfg.iter_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/jet_map.sv
`default_nettype none

module jet_map (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire jet_pkg::cfg_t                  cfg,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [jet_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                                map_valid,
  output jet_pkg::map_item_t                  map_item,
  input  wire logic                           map_ready
);
  import jet_pkg::*;

  logic signed [VAL_W-1:0] zoom_v;
  logic [STEP_W-1:0]       step;
  logic [COORD_W-1:0]      px;
  logic [COORD_W-1:0]      py;
  map_item_t               map_item_next;

  // Start coordinate (p - S/2) * step; the product is exact before saturation.
  function automatic logic signed [VAL_W-1:0] start_coord(input logic [COORD_W-1:0] p,
                                                          input logic [STEP_W-1:0] st);
    logic signed [DIFF_W-1:0]  d;
    logic signed [START_W-1:0] m;
    d = $signed(DIFF_W'(p)) - $signed(DIFF_W'(HALF));
    m = d * $signed({1'b0, st});
    return sat(SAT_W'(m));
  endfunction

  assign px     = s_axis_tdata[COORD_W-1:0];
  assign py     = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign zoom_v = conv_reg($signed(REG_W'(cfg.zoom)));
  assign step   = zoom_v[VAL_W-2:TEX_LOG2];

  always_comb begin
    map_item_next.x  = px;
    map_item_next.y  = py;
    map_item_next.zr = start_coord(px, step);
    map_item_next.zi = start_coord(py, step);
  end

  assign s_axis_tready = !map_valid || map_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= 1'b0;
    end else if (s_axis_tready) begin
      map_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      map_item <= map_item_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jet_ring.sv
`default_nettype none

module jet_ring (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire jet_pkg::cfg_t      cfg,
  input  wire logic               new_valid,
  input  wire jet_pkg::map_item_t new_item,
  output logic                    new_ready,
  output logic                    ret_valid,
  output jet_pkg::res_item_t      ret_item,
  input  wire logic               ret_ready
);
  import jet_pkg::*;

  typedef struct packed {
    logic               done;
    logic [SEQ_W-1:0]   seq;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ITER_W-1:0]  n;
  } tag_t;

  logic                    recirc;
  logic                    retire;
  logic                    take_new;
  logic                    a_valid;
  tag_t                    a_tag;
  logic signed [VAL_W-1:0] a_zr;
  logic signed [VAL_W-1:0] a_zi;
  logic [SEQ_W-1:0]        in_seq;
  logic [SEQ_W-1:0]        out_seq;

  logic                     s1_valid;
  tag_t                     s1_tag;
  logic signed [PROD_W-1:0] s1_prr;
  logic signed [PROD_W-1:0] s1_pii;
  logic signed [PROD_W-1:0] s1_pri;

  logic signed [VAL_W-1:0] b_sr;
  logic signed [VAL_W-1:0] b_si;
  logic signed [VAL_W-1:0] b_pz;
  logic [VAL_W:0]          esc_sum;
  tag_t                    s2_tag_next;

  logic                    s2_valid;
  tag_t                    s2_tag;
  logic signed [VAL_W-1:0] s2_sr;
  logic signed [VAL_W-1:0] s2_si;
  logic signed [VAL_W-1:0] s2_pz;

  logic signed [VAL_W-1:0] cr;
  logic signed [VAL_W-1:0] ci;
  tag_t                    s3_tag_next;
  logic signed [VAL_W-1:0] s3_zr_next;
  logic signed [VAL_W-1:0] s3_zi_next;

  logic                    s3_valid;
  tag_t                    s3_tag;
  logic signed [VAL_W-1:0] s3_zr;
  logic signed [VAL_W-1:0] s3_zi;

  // A finished pixel leaves only in its turn; otherwise it keeps circulating frozen.
  assign ret_valid = s3_valid && s3_tag.done && (s3_tag.seq == out_seq);
  assign retire    = ret_valid && ret_ready;
  assign recirc    = s3_valid && !retire;
  assign new_ready = !recirc;
  assign take_new  = new_valid && new_ready;
  assign a_valid   = recirc || take_new;

  assign ret_item.iter_count = s3_tag.n;
  assign ret_item.x          = s3_tag.x;
  assign ret_item.y          = s3_tag.y;

  always_comb begin
    if (recirc) begin
      a_tag = s3_tag;
      a_zr  = s3_zr;
      a_zi  = s3_zi;
    end else begin
      a_tag.done = 1'b0;
      a_tag.seq  = in_seq;
      a_tag.x    = new_item.x;
      a_tag.y    = new_item.y;
      a_tag.n    = '0;
      a_zr       = new_item.zr;
      a_zi       = new_item.zi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_seq  <= '0;
      out_seq <= '0;
    end else begin
      if (take_new) begin
        in_seq <= in_seq + SEQ_W'(1);
      end
      if (retire) begin
        out_seq <= out_seq + SEQ_W'(1);
      end
    end
  end

  // First stage: the three full products.
  always_ff @(posedge clk) begin
    s1_tag <= a_tag;
    s1_prr <= a_zr * a_zr;
    s1_pii <= a_zi * a_zi;
    s1_pri <= a_zr * a_zi;
  end

  // Second stage: scale products back and test for escape or the limit.
  always_comb begin
    b_sr             = fmul_sat(s1_prr);
    b_si             = fmul_sat(s1_pii);
    b_pz             = fmul_sat(s1_pri);
    esc_sum          = {1'b0, b_sr} + {1'b0, b_si};
    s2_tag_next      = s1_tag;
    s2_tag_next.done = s1_tag.done || (esc_sum >= FOUR) || (s1_tag.n >= cfg.iter_limit);
  end

  always_ff @(posedge clk) begin
    s2_tag <= s2_tag_next;
    s2_sr  <= b_sr;
    s2_si  <= b_si;
    s2_pz  <= b_pz;
  end

  // Third stage: z = z*z + c.
  assign cr = conv_reg(cfg.const_re);
  assign ci = conv_reg(cfg.const_im);

  always_comb begin
    s3_tag_next = s2_tag;
    if (!s2_tag.done) begin
      s3_tag_next.n = s2_tag.n + ITER_W'(1);
    end
    s3_zr_next = sat(SAT_W'(s2_sr) - SAT_W'(s2_si) + SAT_W'(cr));
    s3_zi_next = sat((SAT_W'(s2_pz) <<< 1) + SAT_W'(ci));
  end

  always_ff @(posedge clk) begin
    s3_tag <= s3_tag_next;
    s3_zr  <= s3_zr_next;
    s3_zi  <= s3_zi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= a_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/julia_escape_time_pixel.sv
`default_nettype none

// Julia-set escape-time evaluator for one pixel per transfer. The pixel is
// mapped to z0 = ((x - S/2) * zoom/S, (y - S/2) * zoom/S) in signed Q4.28 and
// iterated as z = z*z + c until |z|^2 reaches 4 or the count reaches iter_limit;
// the count and the pixel coordinates come back in input order. Each iteration
// passes once through the three-stage multiply / scale / add loop, and up to
// three pixels share that loop interleaved, so a new pixel can enter before
// older ones finish. A finished pixel may wait in the loop for an older one to
// leave. The reset iteration limit is 64.
// Registers at byte addresses 0x0 const_re, 0x4 const_im, 0x8 zoom and
// 0xC iter_limit are to be written only while no pixel is in flight.
module julia_escape_time_pixel (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [8:0] pixel_x, [17:9] pixel_y, rest zero
  input  wire logic [jet_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [9:0] iter_count, [18:10] out_x, [27:19] out_y, rest zero
  output logic      [jet_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [jet_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import jet_pkg::*;

  cfg_t      cfg;
  logic      map_valid;
  map_item_t map_item;
  logic      map_ready;
  logic      ret_valid;
  res_item_t ret_item;
  logic      out_free;
  res_item_t out_item;

  jet_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jet_map u_map (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .map_valid     (map_valid),
    .map_item      (map_item),
    .map_ready     (map_ready)
  );

  jet_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .new_valid (map_valid),
    .new_item  (map_item),
    .new_ready (map_ready),
    .ret_valid (ret_valid),
    .ret_item  (ret_item),
    .ret_ready (out_free)
  );

  // Output register; the loop keeps running while a result waits here.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= ret_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ret_valid && out_free) begin
      out_item <= ret_item;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                         out_item.y, out_item.x, out_item.iter_count};

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
  import jet_pkg::*;

  localparam longint VMAX   = (longint'(1) <<< (FRAC_BITS + 3)) - 1;
  localparam longint VMIN   = -VMAX - 1;
  localparam longint FOUR_Q = longint'(4) <<< FRAC_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pixel_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [8:0] pixel_x, [17:9] pixel_y, rest zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [9:0] iter_count, [18:10] out_x, [27:19] out_y, rest zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  cfg_t      view_cfg;
  pixel_t    pixel_queue[$];
  res_item_t awaited_results[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatch_count = 0;
  logic      in_taken = 1'b0;
  bit        stall_arm = 1'b0;
  bit        stall_fired = 1'b0;
  int        hold_left = 0;

  julia_escape_time_pixel u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  function automatic longint clamp_val(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // Product of magnitudes, truncated toward zero, then saturated.
  function automatic longint qmul(input longint a, input longint b);
    longint unsigned ua, ub, q;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    q = (ua * ub) >> FRAC_BITS;
    if ((a < 0) != (b < 0)) begin
      if (q > VMAX + 1) return VMIN;
      return -longint'(q);
    end
    if (q > VMAX) return VMAX;
    return longint'(q);
  endfunction

  function automatic longint start_point(input logic [COORD_W-1:0] p, input longint step);
    longint d, m;
    d = longint'(p) - HALF;
    m = ((d < 0) ? -d : d) * step;
    if (m > VMAX) return (d < 0) ? VMIN : VMAX;
    return (d < 0) ? -m : m;
  endfunction

  function automatic res_item_t escape_count(input pixel_t p);
    longint    step, cr, ci, zr, zi, sr, si, nr;
    int        n;
    res_item_t r;
    step = (longint'(view_cfg.zoom) <<< (FRAC_BITS - REG_FRAC)) / TEXTURE_SIZE;
    cr = longint'($signed(view_cfg.const_re)) <<< (FRAC_BITS - REG_FRAC);
    ci = longint'($signed(view_cfg.const_im)) <<< (FRAC_BITS - REG_FRAC);
    zr = start_point(p.x, step);
    zi = start_point(p.y, step);
    n = 0;
    sr = qmul(zr, zr);
    si = qmul(zi, zi);
    while (sr + si < FOUR_Q && n < view_cfg.iter_limit) begin
      nr = clamp_val(sr - si + cr);
      zi = clamp_val(2 * qmul(zr, zi) + ci);
      zr = nr;
      n++;
      sr = qmul(zr, zr);
      si = qmul(zi, zi);
    end
    r.iter_count = ITER_W'(n);
    r.x = p.x;
    r.y = p.y;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("julia_escape_time_pixel test failed");
    $finish;
  end

  // Pixel driver: a new pixel may go out once the previous one was taken.
  always @(negedge clk) begin : drive_pixels
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(pixel_queue.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long receiver hold-off so that the loop fills and the input backs up.
  always @(negedge clk) begin : long_hold
    if (rst) begin
      hold_left <= 0;
    end else if (stall_arm && !stall_fired) begin
      hold_left   <= 500;
      stall_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : check_results
    res_item_t want, got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(escape_count(pixel_t'(s_axis_tdata[IN_BITS-1:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.iter_count = m_axis_tdata[ITER_W-1:0];
        got.x          = m_axis_tdata[ITER_W +: COORD_W];
        got.y          = m_axis_tdata[ITER_W+COORD_W +: COORD_W];
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected transfer: iter_count %0d out_x %0d out_y %0d",
                     $time, got.iter_count, got.x, got.y);
          end
        end else begin
          want = awaited_results.pop_front();
          if (want.iter_count != got.iter_count || want.x != got.x || want.y != got.y) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"%0t: mismatch: iter_count %0d (exp %0d) out_x %0d (exp %0d)",
                        " out_y %0d (exp %0d)"},
                       $time, got.iter_count, want.iter_count, got.x, want.x, got.y, want.y);
            end
          end
        end
      end
    end
  end

  task automatic push_pixel(input int x, input int y);
    pixel_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    pixel_queue.push_back(p);
  endtask

  task automatic queue_random_pixels(input int count);
    pixel_t p;
    repeat (count) begin
      if ($urandom_range(2) == 0) begin
        p.x = COORD_W'($urandom_range(320, 192));
        p.y = COORD_W'($urandom_range(320, 192));
      end else begin
        p.x = COORD_W'($urandom_range(511));
        p.y = COORD_W'($urandom_range(511));
      end
      pixel_queue.push_back(p);
    end
  endtask

  // Returns once every pixel has been sent and every result has come back.
  // Checked at the rising edge, where the driven valid is already settled.
  task automatic drain();
    while (pixel_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CONST_RE:   view_cfg.const_re   = value;
      REG_CONST_IM:   view_cfg.const_im   = value;
      REG_ZOOM:       view_cfg.zoom       = value[ZOOM_W-1:0];
      REG_ITER_LIMIT: view_cfg.iter_limit = value[ITER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_view(input logic [31:0] cr, input logic [31:0] ci,
                          input logic [ZOOM_W-1:0] zm, input logic [ITER_W-1:0] mi);
    write_reg(REG_CONST_RE, cr);
    write_reg(REG_CONST_IM, ci);
    write_reg(REG_ZOOM, 32'(zm));
    write_reg(REG_ITER_LIMIT, 32'(mi));
  endtask

  // Mostly within [-2, 2], sometimes anywhere in the register range.
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(32'd1073741824)) - 32'd536870912;
  endfunction

  initial begin : run_test
    logic [ZOOM_W-1:0] zm;
    logic [ITER_W-1:0] mi;
    view_cfg.const_re   = RST_CONST_RE;
    view_cfg.const_im   = RST_CONST_IM;
    view_cfg.zoom       = RST_ZOOM;
    view_cfg.iter_limit = RST_ITER_LIMIT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 69;

    // Corners, center and alternating bit patterns at the reset view.
    push_pixel(0, 0);
    push_pixel(511, 511);
    push_pixel(0, 511);
    push_pixel(511, 0);
    push_pixel(256, 256);
    push_pixel(255, 255);
    push_pixel(257, 256);
    push_pixel(256, 0);
    push_pixel(0, 256);
    push_pixel(170, 341);
    push_pixel(341, 170);
    drain();

    // A zero iteration limit returns a count of zero everywhere.
    set_view(rand_coef(), rand_coef(), '1, '0);
    push_pixel(0, 0);
    push_pixel(256, 256);
    push_pixel(511, 511);
    drain();

    // Extreme constants: sums and products saturate at the format limits.
    set_view(32'h7FFF_FFFF, 32'h8000_0000, '1, '1);
    push_pixel(256, 256);
    push_pixel(0, 511);
    drain();
    set_view(32'h8000_0000, 32'h7FFF_FFFF, '1, '1);
    push_pixel(511, 0);
    push_pixel(256, 256);
    drain();

    // Zero zoom puts every pixel at the origin; c = 0 and c = -1 never escape.
    set_view(32'h0, 32'h0, '0, '1);
    push_pixel(100, 400);
    drain();
    set_view(32'hF000_0000, 32'h0, '0, '1);
    push_pixel(400, 100);
    drain();

    for (int k = 0; k < 11; k++) begin
      if (k < 4) begin
        send_idle_pct = 18;
        recv_idle_pct = 69;
      end else if (k < 8) begin
        send_idle_pct = 69;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(7))
        0:       zm = '0;
        1:       zm = '1;
        2:       zm = ZOOM_W'($urandom);
        default: zm = ZOOM_W'($urandom_range(32'd1610612736, 32'd67108864));
      endcase
      case ($urandom_range(7))
        0:       mi = '0;
        1:       mi = ITER_W'($urandom_range(127, 65));
        default: mi = ITER_W'($urandom_range(40, 1));
      endcase
      set_view(rand_coef(), rand_coef(), zm, mi);
      queue_random_pixels(150);
      drain();
    end

    // Short iteration limit with the receiver held off for a long stretch.
    set_view(rand_coef(), rand_coef(), ZOOM_W'($urandom_range(32'd1610612736, 32'd67108864)),
             ITER_W'(5));
    stall_arm = 1'b1;
    queue_random_pixels(60);
    drain();

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("julia_escape_time_pixel test passed");
    end else begin
      $display("julia_escape_time_pixel test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
